// ===== sv/opm_pkg.sv =====
// Shared types, constants and trigonometry tables for the obstacle point mapper.
package opm_pkg;

  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned ANG_W       = 9;
  localparam int unsigned DIST_W      = 15;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned ENTRY_W     = 2 * COORD_W;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [CNT_W-1:0] RESET_RING_SIZE = 11'd1024;

  // Request kinds carried on in_tuser.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LOOK,
    ST_MUL,
    ST_ADD_DONE,
    ST_RD_DONE
  } opm_state_t;

  // Stage enables from the sequencer to the trig datapath.
  typedef struct packed {
    logic head_en;
    logic look_en;
    logic mul_en;
  } opm_trig_ctl_t;

  typedef logic [90:0][15:0] opm_sine_tbl_t;

  localparam logic [63:0] PI_Q61          = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] RAD_PER_DEG_Q61 = PI_Q61 / 64'd180;

  // Denominators (2n)(2n+1) of the sine series, term n at index n.
  localparam logic [12:1][9:0] TAYLOR_DIV = {
    10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
    10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
  };

  // Product of two Q3.61 values, kept in Q3.61.
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // Rounded sine magnitude in Q1.15 for 0 to 90 degrees, used at elaboration only.
  function automatic logic [15:0] sine_mag(input int unsigned deg);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = RAD_PER_DEG_Q61 * 64'(deg);
    x2   = mul_q61(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      term = mul_q61(term, x2) / 64'(TAYLOR_DIV[n]);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return 16'((sum + (64'd1 << 45)) >> 46);
  endfunction

  function automatic opm_sine_tbl_t build_sine_tbl();
    opm_sine_tbl_t tbl;
    for (int d = 0; d <= 90; d++) begin
      tbl[d] = sine_mag(d);
    end
    return tbl;
  endfunction

  localparam opm_sine_tbl_t SINE_MAG = build_sine_tbl();

  // Sum of two angles reduced to 0..359.
  function automatic logic [ANG_W-1:0] reduce_heading(input logic [ANG_W-1:0] va,
                                                      input logic [ANG_W-1:0] sa);
    logic [ANG_W:0] s;
    s = {1'b0, va} + {1'b0, sa};
    if (s >= 10'd720) begin
      s = s - 10'd720;
    end else if (s >= 10'd360) begin
      s = s - 10'd360;
    end
    return s[ANG_W-1:0];
  endfunction

  // Q1.15 sine of a heading in 0..359, folded onto the quarter-wave table.
  function automatic logic signed [15:0] sin_q15(input logic [ANG_W-1:0] h);
    logic [1:0]        q;
    logic [ANG_W-1:0]  r;
    logic [6:0]        idx;
    logic [16:0]       mag;
    logic signed [15:0] res;
    if (h < 9'd90) begin
      q = 2'd0;
      r = h;
    end else if (h < 9'd180) begin
      q = 2'd1;
      r = h - 9'd90;
    end else if (h < 9'd270) begin
      q = 2'd2;
      r = h - 9'd180;
    end else begin
      q = 2'd3;
      r = h - 9'd270;
    end
    idx = q[0] ? 7'(9'd90 - r) : 7'(r);
    mag = {1'b0, SINE_MAG[idx]};
    if (q[1]) begin
      res = 16'(-$signed(mag));
    end else begin
      res = (mag > 17'd32767) ? 16'sd32767 : 16'(mag);
    end
    return res;
  endfunction

  function automatic logic signed [15:0] cos_q15(input logic [ANG_W-1:0] h);
    logic [ANG_W:0] h2;
    h2 = {1'b0, h} + 10'd90;
    if (h2 >= 10'd360) begin
      h2 = h2 - 10'd360;
    end
    return sin_q15(h2[ANG_W-1:0]);
  endfunction

endpackage

// ===== sv/opm_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module opm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/opm_trig.sv =====
// Heading reduction, sine and cosine lookup and range products, one stage per step.
module opm_trig (
  input  logic                                clk,
  input  opm_pkg::opm_trig_ctl_t              ctl,
  input  logic [opm_pkg::ANG_W-1:0]           vehicle_angle,
  input  logic [opm_pkg::ANG_W-1:0]           sensor_angle,
  input  logic [opm_pkg::DIST_W-1:0]          distance,
  output logic signed [opm_pkg::PROD_W-1:0]   prod_x,
  output logic signed [opm_pkg::PROD_W-1:0]   prod_y
);

  logic [opm_pkg::ANG_W-1:0]         heading_r;
  logic signed [opm_pkg::COORD_W-1:0] cos_r;
  logic signed [opm_pkg::COORD_W-1:0] sin_r;
  logic signed [opm_pkg::PROD_W-1:0]  prod_x_r;
  logic signed [opm_pkg::PROD_W-1:0]  prod_y_r;
  logic signed [opm_pkg::COORD_W-1:0] dist_s;

  assign dist_s = $signed({1'b0, distance});

  always_ff @(posedge clk) begin
    if (ctl.head_en) begin
      heading_r <= opm_pkg::reduce_heading(vehicle_angle, sensor_angle);
    end
    if (ctl.look_en) begin
      cos_r <= opm_pkg::cos_q15(heading_r);
      sin_r <= opm_pkg::sin_q15(heading_r);
    end
    if (ctl.mul_en) begin
      prod_x_r <= opm_pkg::PROD_W'(dist_s) * opm_pkg::PROD_W'(cos_r);
      prod_y_r <= opm_pkg::PROD_W'(dist_s) * opm_pkg::PROD_W'(sin_r);
    end
  end

  assign prod_x = prod_x_r;
  assign prod_y = prod_y_r;

endmodule

// ===== sv/obstacle_point_mapper_unit.sv =====
// Top level of the obstacle point mapper: sequencer, point ring memory and output register.
// An add request passes the heading, table and multiply stages before its result is registered;
// a read request takes its ring data in the step after acceptance. Both wait while the output
// register is held, and the one-request-at-a-time sequencer takes no new request until then.
// Reset clears the write pointer and the point count and sets the ring size to 1024
// (limited to RING_DEPTH); the point ring itself is not cleared, no sweep is needed.
module obstacle_point_mapper_unit #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input tdata, lowest bit up: pos_x[15:0], pos_y[15:0], vehicle_angle[8:0],
  // sensor_angle[8:0], distance[14:0], read_index[9:0], zero fill.
  input  logic [opm_pkg::IN_TDATA_W-1:0]       in_tdata,
  // Input tuser: op (0 add, 1 read).
  input  logic [0:0]                           in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Output tdata, lowest bit up: point_x[15:0], point_y[15:0], slot[9:0],
  // stored_count[10:0], zero fill.
  output logic [opm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Output tuser: valid_res.
  output logic [0:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wr_en,
  input  logic [opm_pkg::CNT_W-1:0]            cfg_wr_data
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [opm_pkg::CNT_W-1:0] SIZE_AT_RESET =
    (RING_DEPTH < 1024) ? opm_pkg::CNT_W'(RING_DEPTH) : opm_pkg::RESET_RING_SIZE;

  // Unpacked view of the incoming request.
  logic                                in_op;
  logic signed [opm_pkg::COORD_W-1:0]  in_pos_x;
  logic signed [opm_pkg::COORD_W-1:0]  in_pos_y;
  logic [opm_pkg::ANG_W-1:0]           in_vehicle_angle;
  logic [opm_pkg::ANG_W-1:0]           in_sensor_angle;
  logic [opm_pkg::DIST_W-1:0]          in_distance;
  logic [opm_pkg::SLOT_W-1:0]          in_read_index;

  assign in_op            = in_tuser[0];
  assign in_pos_x         = in_tdata[15:0];
  assign in_pos_y         = in_tdata[31:16];
  assign in_vehicle_angle = in_tdata[40:32];
  assign in_sensor_angle  = in_tdata[49:41];
  assign in_distance      = in_tdata[64:50];
  assign in_read_index    = in_tdata[74:65];

  opm_pkg::opm_state_t state_r, state_nxt;

  // Captured request payload; it holds until the request has finished.
  logic signed [opm_pkg::COORD_W-1:0]  pos_x_r;
  logic signed [opm_pkg::COORD_W-1:0]  pos_y_r;
  logic [opm_pkg::ANG_W-1:0]           va_r;
  logic [opm_pkg::ANG_W-1:0]           sa_r;
  logic [opm_pkg::DIST_W-1:0]          dist_r;
  logic [opm_pkg::SLOT_W-1:0]          ridx_r;

  // Ring bookkeeping. The write pointer is as wide as the ring size so that it can
  // reach every slot of the largest ring that can be configured.
  logic [opm_pkg::CNT_W-1:0]           wp_r, wp_nxt;
  logic [opm_pkg::CNT_W-1:0]           count_r, count_nxt;
  logic [opm_pkg::CNT_W-1:0]           size_r, size_nxt;

  // Output register.
  logic                                out_valid_r, out_valid_nxt;
  logic [opm_pkg::OUT_TDATA_W-1:0]     out_data_r, out_data_nxt;
  logic                                out_user_r, out_user_nxt;

  opm_pkg::opm_trig_ctl_t              trig_ctl;
  logic signed [opm_pkg::PROD_W-1:0]   prod_x;
  logic signed [opm_pkg::PROD_W-1:0]   prod_y;

  logic                                ram_wr_en;
  logic                                ram_rd_en;
  logic [AW-1:0]                       ram_wr_addr;
  logic [AW-1:0]                       ram_rd_addr;
  logic [opm_pkg::ENTRY_W-1:0]         ram_wr_data;
  logic [opm_pkg::ENTRY_W-1:0]         ram_rd_data;

  logic                                accept;
  logic                                out_free;
  logic [opm_pkg::CNT_W-1:0]           slot;
  logic [opm_pkg::CNT_W-1:0]           slot_inc;
  logic signed [opm_pkg::PROD_W-1:0]   adj_x;
  logic signed [opm_pkg::PROD_W-1:0]   adj_y;
  logic signed [opm_pkg::PROD_W-1:0]   off_x;
  logic signed [opm_pkg::PROD_W-1:0]   off_y;
  logic [opm_pkg::COORD_W-1:0]         add_x;
  logic [opm_pkg::COORD_W-1:0]         add_y;
  logic                                rd_ok;
  logic [opm_pkg::CNT_W-1:0]           cfg_size;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // A written size of zero acts as one, and sizes past the ring depth act as the depth.
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_size = opm_pkg::CNT_W'(1);
    end else if (32'(cfg_wr_data) > 32'(RING_DEPTH)) begin
      cfg_size = opm_pkg::CNT_W'(RING_DEPTH);
    end else begin
      cfg_size = cfg_wr_data;
    end
  end

  opm_trig u_trig (
    .clk           (clk),
    .ctl           (trig_ctl),
    .vehicle_angle (va_r),
    .sensor_angle  (sa_r),
    .distance      (dist_r),
    .prod_x        (prod_x),
    .prod_y        (prod_y)
  );

  opm_ram #(
    .WIDTH (opm_pkg::ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The slot written by an add. The pointer always stays below the size, so the
  // fallback to slot zero only guards a pointer left over from a larger ring.
  assign slot     = (wp_r < size_r) ? wp_r : '0;
  assign slot_inc = slot + opm_pkg::CNT_W'(1);

  // Offsets are the Q1.15 products divided by 32768 with truncation toward zero:
  // negative products get a bias of 32767 before the arithmetic shift.
  assign adj_x = prod_x + (prod_x[opm_pkg::PROD_W-1] ? 32'sd32767 : 32'sd0);
  assign adj_y = prod_y + (prod_y[opm_pkg::PROD_W-1] ? 32'sd32767 : 32'sd0);
  assign off_x = adj_x >>> 15;
  assign off_y = adj_y >>> 15;
  assign add_x = pos_x_r + off_x[opm_pkg::COORD_W-1:0];
  assign add_y = pos_y_r + off_y[opm_pkg::COORD_W-1:0];

  // A read returns a point only for a slot below the count that the ring can hold.
  assign rd_ok = ({1'b0, ridx_r} < count_r) && (32'(ridx_r) < 32'(RING_DEPTH));

  assign ram_wr_addr = AW'({{AW{1'b0}}, slot});
  assign ram_rd_addr = AW'({{AW{1'b0}}, in_read_index});
  assign ram_wr_data = {add_y, add_x};

  // Sequencer: one request at a time. The output register lets a new request be
  // accepted while the previous result still waits on the output side.
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    trig_ctl      = '0;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    size_nxt      = size_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    unique case (state_r)
      opm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          if (in_op == opm_pkg::OP_READ) begin
            // The ring read is issued straight from the request so that the data
            // is ready in the next cycle.
            ram_rd_en = 1'b1;
            state_nxt = opm_pkg::ST_RD_DONE;
          end else begin
            state_nxt = opm_pkg::ST_HEAD;
          end
        end
      end
      opm_pkg::ST_HEAD: begin
        trig_ctl.head_en = 1'b1;
        state_nxt        = opm_pkg::ST_LOOK;
      end
      opm_pkg::ST_LOOK: begin
        trig_ctl.look_en = 1'b1;
        state_nxt        = opm_pkg::ST_MUL;
      end
      opm_pkg::ST_MUL: begin
        trig_ctl.mul_en = 1'b1;
        state_nxt       = opm_pkg::ST_ADD_DONE;
      end
      opm_pkg::ST_ADD_DONE: begin
        // The point is stored and the ring advanced only once the result can be
        // placed in the output register, so a stall repeats nothing.
        if (out_free) begin
          ram_wr_en     = 1'b1;
          wp_nxt        = (slot_inc == size_r) ? '0 : slot_inc;
          if (count_r < size_r) begin
            count_nxt = count_r + opm_pkg::CNT_W'(1);
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, count_nxt, slot[opm_pkg::SLOT_W-1:0], add_y, add_x};
          out_user_nxt  = 1'b1;
          state_nxt     = opm_pkg::ST_IDLE;
        end
      end
      opm_pkg::ST_RD_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, count_r, ridx_r,
                           rd_ok ? ram_rd_data : {opm_pkg::ENTRY_W{1'b0}}};
          out_user_nxt  = rd_ok;
          state_nxt     = opm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = opm_pkg::ST_IDLE;
      end
    endcase

    // A size write empties the ring; write it only while the block is idle (not enforced).
    if (cfg_wr_en) begin
      size_nxt  = cfg_size;
      wp_nxt    = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= opm_pkg::ST_IDLE;
      wp_r        <= '0;
      count_r     <= '0;
      size_r      <= SIZE_AT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    if (accept) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      va_r    <= in_vehicle_angle;
      sa_r    <= in_sensor_angle;
      dist_r  <= in_distance;
      ridx_r  <= in_read_index;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // The count never passes the active ring size.
  a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= size_r)
    else $error("point count above ring size");

  // The write pointer always addresses a slot inside the active ring.
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < size_r)
    else $error("write pointer outside ring");

  // After a point is stored the ring holds at least one point.
  a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en && !cfg_wr_en |=> count_r != '0)
    else $error("point stored but count is zero");

  // A read request goes straight to the step that takes the ring data.
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == opm_pkg::OP_READ |=> state_r == opm_pkg::ST_RD_DONE)
    else $error("read request left the read path");

  // A result flagged invalid carries a zero point.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r |-> out_data_r[opm_pkg::ENTRY_W-1:0] == '0)
    else $error("invalid result with nonzero point");

endmodule
